FILE: sv/longest_prefix_match_table_macros.svh
// ----------------------------------------------------------------------------
// Longest prefix match table: assertion macros
// Concurrent assertion wrappers shared by the table's modules.
// ----------------------------------------------------------------------------
`ifndef LONGEST_PREFIX_MATCH_TABLE_MACROS_SVH
`define LONGEST_PREFIX_MATCH_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on clk_i, switched off while rst_ni is low.
`define LPM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Same check on a clock and active-low reset given by the caller.
`define LPM_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define LPM_ASSERT(name, prop, msg)
`define LPM_ASSERT_CLK(name, clk, rst_n, prop, msg)
`endif
`endif

FILE: sv/lpm_pkg.sv
// ----------------------------------------------------------------------------
// Longest prefix match table: package
// Transfer types, status codes and the prefix mask helper.
// ----------------------------------------------------------------------------
package lpm_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned LenW    = 6;
  localparam int unsigned PortW   = 4;
  localparam int unsigned StatusW = 2;
  localparam int unsigned TopBit  = 31;
  localparam logic [LenW-1:0] FullLength = LenW'(TopBit + 1);

  localparam logic OpInsert = 1'b0;
  localparam logic OpLookup = 1'b1;

  localparam logic [StatusW-1:0] StatusOk      = 2'd0;
  localparam logic [StatusW-1:0] StatusNoRoute = 2'd1;
  localparam logic [StatusW-1:0] StatusFull    = 2'd2;

  typedef struct packed {
    logic              opcode;
    logic [AddrW-1:0]  address;
    logic [LenW-1:0]   prefix_length;
    logic [AddrW-1:0]  hop_address;
    logic [PortW-1:0]  egress_port;
  } lpm_req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [AddrW-1:0]   found_hop;
    logic [PortW-1:0]   found_port;
    logic [LenW-1:0]    found_length;
  } lpm_rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic rd_en;
    logic finish;
  } lpm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic count_zero;
    logic scan_last;
  } lpm_sts_t;

  // Mask with the top len bits set; len is 0 to 32.
  function automatic logic [AddrW-1:0] length_mask(input logic [LenW-1:0] len);
    logic [AddrW-1:0] m;
    if (len == '0) begin
      m = '0;
    end else begin
      m = {AddrW{1'b1}} << (FullLength - len);
    end
    return m;
  endfunction

endpackage

FILE: sv/longest_prefix_match_table.sv
// ----------------------------------------------------------------------------
// Longest prefix match table: with N stored routes (at most TABLE_DEPTH) an
// item is taken, scanned with one read per route, drained of its last read
// and finished; on an empty table it goes straight to the finish. One item
// at a time; the receiver cannot stall. Busy falls as the result strobe
// shows: no item is taken before the last is through. Reset empties the table.
// ----------------------------------------------------------------------------
//
// The table keeps IPv4 routes in a memory filled from entry zero upwards.
// Routes are never removed, so the fill count tells which entries hold data
// and no per-entry valid bits are needed.
//
// An insert masks its prefix to its length (lengths above 32 are treated as
// 32) and scans the stored routes for one with the same prefix and length.
// A hit has its next hop and port rewritten in place; otherwise the route is
// appended at the fill count, or dropped with a table full status when there
// is no room left.
//
// A lookup scans all stored routes and keeps the longest one whose prefix
// matches the destination. A zero-length route is the default route and
// matches every address. Without a match the status reports no route.
//
// Each transfer in is taken when start is high and busy is low. Each result
// transfer is shown on rsp_o for exactly one cycle with result_valid_o high;
// the receiver cannot hold it off.

module longest_prefix_match_table import lpm_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned PORT_BITS   = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  lpm_req_t req_i,
  output logic     result_valid_o,
  output lpm_rsp_t rsp_o
);

  lpm_cmd_t cmd;
  lpm_sts_t sts;

  // Controller: walks idle, scan, drain of the last read, then finish; an empty table goes from idle to finish.
  lpm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Datapath: route memory with registered read, compare stage and the
  // registered result that drives the output ports.
  lpm_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PORT_BITS   (PORT_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

endmodule

FILE: sv/lpm_ctrl.sv
// ----------------------------------------------------------------------------
// Longest prefix match table: controller
// Sequences the table scan and the final write or result of each item.
// ----------------------------------------------------------------------------
`include "longest_prefix_match_table_macros.svh"

module lpm_ctrl import lpm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  lpm_sts_t sts_i,
  output lpm_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDrain,
    StFinish
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.count_zero ? StFinish : StScan;
        end
      end
      StScan: begin
        cmd_o.rd_en = 1'b1;
        if (sts_i.scan_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StFinish;
      end
      StFinish: begin
        cmd_o.finish = 1'b1;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != StIdle);

  `LPM_ASSERT_CLK(a_accept_sets_busy, clk_i, rst_ni, (start && !busy) |=> busy, "busy not raised after an accepted item")
  `LPM_ASSERT(a_scan_needs_entries, (state_q == StScan) |-> !sts_i.count_zero, "scan started on an empty table")

endmodule

FILE: sv/lpm_datapath.sv
// ----------------------------------------------------------------------------
// Longest prefix match table: datapath
// Route memory, fill count, scan compare and result registers.
// ----------------------------------------------------------------------------
`include "longest_prefix_match_table_macros.svh"

module lpm_datapath import lpm_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned PORT_BITS   = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  lpm_req_t req_i,
  input  lpm_cmd_t cmd_i,
  output lpm_sts_t sts_o,
  output logic     result_valid_o,
  output lpm_rsp_t rsp_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic [AddrW-1:0]     prefix;
    logic [LenW-1:0]      length;
    logic [AddrW-1:0]     hop;
    logic [PORT_BITS-1:0] port;
  } entry_t;

  entry_t entry_mem [TABLE_DEPTH];

  logic [CntW-1:0]      count_q;
  logic [IdxW-1:0]      idx_q;
  logic [IdxW-1:0]      rd_idx_q;
  logic                 rd_valid_q;
  entry_t               rd_data_q;

  logic                 op_q;
  logic [AddrW-1:0]     item_addr_q;
  logic [LenW-1:0]      item_len_q;
  logic [AddrW-1:0]     item_hop_q;
  logic [PORT_BITS-1:0] item_port_q;

  logic                 found_q;
  logic [IdxW-1:0]      best_idx_q;
  logic [AddrW-1:0]     best_hop_q;
  logic [PORT_BITS-1:0] best_port_q;
  logic [LenW-1:0]      best_len_q;

  logic                 result_valid_q;
  lpm_rsp_t             rsp_q;
  lpm_rsp_t             rsp_d;

  logic [LenW-1:0]      sat_len;
  logic                 lookup_hit;
  logic                 insert_hit;
  logic                 take;
  logic                 table_full;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_addr;

  // Insert lengths above 32 saturate; the prefix is masked on entry.
  assign sat_len = (req_i.prefix_length > FullLength) ? FullLength : req_i.prefix_length;

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.scan_last  = (CntW'(idx_q) == (count_q - CntW'(1)));

  assign lookup_hit = ((item_addr_q & length_mask(rd_data_q.length)) == rd_data_q.prefix);
  assign insert_hit = (rd_data_q.prefix == item_addr_q) && (rd_data_q.length == item_len_q);

  // The first match wins on insert; on lookup only a strictly longer one replaces it.
  always_comb begin
    if (op_q == OpInsert) begin
      take = rd_valid_q && insert_hit && !found_q;
    end else begin
      take = rd_valid_q && lookup_hit && (!found_q || (rd_data_q.length > best_len_q));
    end
  end

  assign table_full = (count_q == CntW'(TABLE_DEPTH));
  assign wr_en      = cmd_i.finish && (op_q == OpInsert) && (found_q || !table_full);
  assign wr_addr    = found_q ? best_idx_q : count_q[IdxW-1:0];

  // Result of the item, loaded into the result register on finish.
  always_comb begin
    rsp_d = '0;
    if (op_q == OpInsert) begin
      rsp_d.status = (found_q || !table_full) ? StatusOk : StatusFull;
    end else if (found_q) begin
      rsp_d.status       = StatusOk;
      rsp_d.found_hop    = best_hop_q;
      rsp_d.found_port   = PortW'(best_port_q);
      rsp_d.found_length = best_len_q;
    end else begin
      rsp_d.status = StatusNoRoute;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= entry_mem[idx_q];
    end
    if (wr_en) begin
      entry_mem[wr_addr] <= '{prefix: item_addr_q, length: item_len_q,
                              hop: item_hop_q, port: item_port_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q        <= req_i.opcode;
      item_addr_q <= (req_i.opcode == OpInsert) ?
                     (req_i.address & length_mask(sat_len)) : req_i.address;
      item_len_q  <= sat_len;
      item_hop_q  <= req_i.hop_address;
      item_port_q <= PORT_BITS'(req_i.egress_port);
    end
    if (cmd_i.rd_en) begin
      rd_idx_q <= idx_q;
    end
    if (take) begin
      best_idx_q  <= rd_idx_q;
      best_hop_q  <= rd_data_q.hop;
      best_port_q <= rd_data_q.port;
      best_len_q  <= rd_data_q.length;
    end
    if (cmd_i.finish) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      idx_q          <= '0;
      rd_valid_q     <= 1'b0;
      found_q        <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      rd_valid_q     <= cmd_i.rd_en;
      result_valid_q <= cmd_i.finish;
      if (cmd_i.load) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.rd_en) begin
          idx_q <= idx_q + 1'b1;
        end
        if (take) begin
          found_q <= 1'b1;
        end
      end
      if (wr_en && !found_q) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  assign result_valid_o = result_valid_q;
  assign rsp_o          = rsp_q;

  `LPM_ASSERT(a_count_bound, count_q <= CntW'(TABLE_DEPTH), "fill count beyond table depth")
  `LPM_ASSERT(a_read_in_fill, rd_valid_q |-> (CntW'(rd_idx_q) < count_q), "scan read past the filled entries")
  `LPM_ASSERT(a_full_only_when_full, (result_valid_q && (rsp_q.status == StatusFull)) |-> table_full, "table full reported with free entries")

endmodule
